// File: hw/rtl/mtmq_pkg.sv
package mtmq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int MAX_DRAIN = 16;
    localparam int BUDGET_WIDTH = 5;
    localparam logic [BUDGET_WIDTH-1:0] BUDGET_RESET = 5'd4;

    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CLOCK    = 8'hF8;
    localparam logic [7:0] STATUS_START    = 8'hFA;
    localparam logic [7:0] STATUS_CONTINUE = 8'hFB;
    localparam logic [7:0] STATUS_STOP     = 8'hFC;
    localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;

    localparam logic [1:0] BYTES_SHORT = 2'd1;
    localparam logic [1:0] BYTES_NOTE  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_CLOCK    = 3'd2,
        CMD_START    = 3'd3,
        CMD_CONTINUE = 3'd4,
        CMD_STOP     = 3'd5,
        CMD_SERVICE  = 3'd6
    } cmd_e;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } back_state_e;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] channel;
        logic [6:0] note_number;
        logic [6:0] velocity;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] byte_count;
        logic       last_of_drain;
    } msg_item_t;

    // One stored message: status and the two data bytes
    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } msg_word_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic      service;
        msg_word_t word;
    } job_t;

endpackage

// File: hw/rtl/mtmq_front.sv
module mtmq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  mtmq_pkg::cmd_item_t cmd,
    output logic              job_valid,
    input  logic              job_ready,
    output mtmq_pkg::job_t    job
);
    import mtmq_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    job_t       classified;
    logic       keep;
    logic       push;
    logic       pop;

    // Encode the command into a message word or mark it as a service; drop the unused code
    always_comb
    begin
        classified = '0;
        keep       = 1'b1;
        case (cmd_e'(cmd.command))
            CMD_NOTE_ON:
            begin
                classified.word.status   = STATUS_NOTE_ON | {4'h0, cmd.channel};
                classified.word.data_one = cmd.note_number;
                classified.word.data_two = cmd.velocity;
            end
            CMD_NOTE_OFF:
            begin
                classified.word.status   = STATUS_NOTE_OFF | {4'h0, cmd.channel};
                classified.word.data_one = cmd.note_number;
            end
            CMD_CLOCK:    classified.word.status = STATUS_CLOCK;
            CMD_START:    classified.word.status = STATUS_START;
            CMD_CONTINUE: classified.word.status = STATUS_CONTINUE;
            CMD_STOP:     classified.word.status = STATUS_STOP;
            CMD_SERVICE:  classified.service = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign cmd_ready = (fill_reg != 2'd2);
    assign job_valid = (fill_reg != 2'd0);
    assign job       = slot_reg[rd_ptr_reg];
    assign push      = cmd_valid && cmd_ready && keep;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: hw/rtl/mtmq_back.sv
module mtmq_back #(
    parameter int QUEUE_DEPTH = mtmq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [mtmq_pkg::BUDGET_WIDTH-1:0]     drain_budget,
    input  logic                                  job_valid,
    output logic                                  job_ready,
    input  mtmq_pkg::job_t                        job,
    output logic                                  msg_valid,
    input  logic                                  msg_ready,
    output mtmq_pkg::msg_item_t                   msg
);
    import mtmq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = (CW > BUDGET_WIDTH) ? CW : BUDGET_WIDTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [BUDGET_WIDTH-1:0] BUDGET_CAP = BUDGET_WIDTH'(MAX_DRAIN);

    msg_word_t                store [QUEUE_DEPTH];
    msg_word_t                rd_data_reg;
    back_state_e              state_reg;
    back_state_e              state_next;
    logic [AW-1:0]            wr_slot_reg;
    logic [AW-1:0]            wr_slot_next;
    logic [AW-1:0]            rd_slot_reg;
    logic [AW-1:0]            rd_slot_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [BUDGET_WIDTH-1:0]  remain_reg;
    logic [BUDGET_WIDTH-1:0]  remain_next;
    logic                     msg_valid_reg;
    logic                     msg_valid_next;
    msg_item_t                msg_reg;
    msg_item_t                msg_next;
    logic                     wr_en;
    logic [BUDGET_WIDTH-1:0]  budget_sat;
    logic [MW-1:0]            occ_ext;
    logic [MW-1:0]            bud_ext;
    logic [MW-1:0]            drain_n;
    logic                     out_free;

    assign budget_sat = (drain_budget > BUDGET_CAP) ? BUDGET_CAP : drain_budget;
    assign occ_ext    = MW'(count_reg);
    assign bud_ext    = MW'(budget_sat);
    assign drain_n    = (occ_ext < bud_ext) ? occ_ext : bud_ext;
    assign out_free   = !msg_valid_reg || msg_ready;

    assign job_ready = (state_reg == BK_IDLE);
    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;

    always_comb
    begin
        state_next     = state_reg;
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        msg_valid_next = msg_valid_reg && !msg_ready;
        msg_next       = msg_reg;
        wr_en          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.service)
                    begin
                        remain_next = BUDGET_WIDTH'(drain_n);
                        if (drain_n != '0)
                        begin
                            state_next = BK_READ;
                        end
                    end
                    else if (count_reg != FULL_COUNT)
                    begin
                        wr_en        = 1'b1;
                        wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (out_free)
                begin
                    msg_valid_next        = 1'b1;
                    msg_next.status_byte  = rd_data_reg.status;
                    msg_next.data_one     = rd_data_reg.data_one;
                    msg_next.data_two     = rd_data_reg.data_two;
                    msg_next.byte_count   = (rd_data_reg.status >= STATUS_SYSTEM) ?
                                            BYTES_SHORT : BYTES_NOTE;
                    msg_next.last_of_drain = (remain_reg == BUDGET_WIDTH'(1));
                    rd_slot_next = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                    remain_next  = remain_reg - 1'b1;
                    state_next   = (remain_reg == BUDGET_WIDTH'(1)) ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            msg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            msg_valid_reg <= msg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

    // Message store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_slot_reg] <= job.word;
        end
        rd_data_reg <= store[rd_slot_reg];
    end

endmodule

// File: hw/rtl/midi_tx_message_queue_unit.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// command   | cmd_valid / cmd_ready  | cmd : command, channel, note_number, velocity
// message   | msg_valid / msg_ready  | msg : status_byte, data_one, data_two,
//           |                        |       byte_count, last_of_drain
// config    | cfg_write (no wait)    | cfg_wdata : drain_budget
//
// Flow: a command is taken into a two-entry command queue. The back end takes an enqueue
// in its idle state; a service sets the drain count there and then, for each message
// emitted, passes a registered store read (BK_READ) and a load of the output register (BK_LOAD).
// Reset clears the pointers, the fill count and both queues and sets the budget to four;
// the message store is not cleared. A stalled output holds the drain; the command queue
// keeps taking transfers until it fills.
module midi_tx_message_queue_unit #(
    parameter int QUEUE_DEPTH = mtmq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  mtmq_pkg::cmd_item_t               cmd,
    output logic                              msg_valid,
    input  logic                              msg_ready,
    output mtmq_pkg::msg_item_t               msg,
    input  logic                              cfg_write,
    input  logic [mtmq_pkg::BUDGET_WIDTH-1:0] cfg_wdata
);
    import mtmq_pkg::*;

    logic [BUDGET_WIDTH-1:0] drain_budget_reg;
    logic [BUDGET_WIDTH-1:0] drain_budget_next;
    logic                    job_valid;
    logic                    job_ready;
    job_t                    job;

    // Drain budget: to be written only while the block is idle; the block does not enforce it
    assign drain_budget_next = cfg_write ? cfg_wdata : drain_budget_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_budget_reg <= BUDGET_RESET;
        end
        else
        begin
            drain_budget_reg <= drain_budget_next;
        end
    end

    // Front end: classify each transfer and hold all but the unused code in the command queue
    mtmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Back end: store messages in the ring and drain them on service
    mtmq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .drain_budget (drain_budget_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg)
    );

endmodule

// File: sim/tb_midi_tx_message_queue_unit.sv
// Testbench for the MIDI transmit message queue.
//
// Commands go in on the cmd channel. Every command transfer updates a model of the
// FIFO in the testbench. A service command moves the messages it drains into a queue
// of awaited messages, and every message transfer on the msg channel must match the
// oldest one there.
module tb_midi_tx_message_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mtmq_pkg::*;

    localparam int FIFO_DEPTH      = QUEUE_DEPTH_DEFAULT;
    localparam int RESET_CYCLES    = 6;
    // Cycles to let pass after the last awaited message before touching the budget.
    // A command that yields nothing may still sit in the command queue or the back end.
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 31;

    // The only 3-bit command code without a meaning; the block must ignore it
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Markers in the stimulus table
    localparam int NO_WRITE  = -1;
    localparam int NOT_TYPED = -1;

    typedef struct {
        int        budget;   // value written to drain_budget before the row, or NO_WRITE
        cmd_item_t item;
        int        reps;
        int        exp_n;    // messages the row drains, or NOT_TYPED
        msg_item_t want;     // first message drained, where exp_n is above zero
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd       = '0;
    logic        msg_valid;
    logic        msg_ready = 1'b0;
    msg_item_t   msg;
    logic        cfg_write = 1'b0;
    logic [BUDGET_WIDTH-1:0] cfg_wdata = '0;

    // Model of the block: FIFO contents, budget register and messages in flight
    msg_word_t   fifo_words[$];
    logic [BUDGET_WIDTH-1:0] budget_model = BUDGET_RESET;
    msg_item_t   pending_msgs[$];

    int          error_count   = 0;
    int          cycle_count   = 0;
    int          cmds_sent     = 0;
    int          msgs_checked  = 0;
    int          dropped_msgs  = 0;
    int          budget_writes = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    midi_tx_message_queue_unit #(
        .QUEUE_DEPTH(FIFO_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .cfg_write (cfg_write),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_msg(input string where, input msg_item_t got, input msg_item_t want);
        if (got.status_byte !== want.status_byte)
            report_mismatch($sformatf("%s: status_byte %h, awaited %h", where,
                                      got.status_byte, want.status_byte));
        if (got.data_one !== want.data_one)
            report_mismatch($sformatf("%s: data_one %0d, awaited %0d", where,
                                      got.data_one, want.data_one));
        if (got.data_two !== want.data_two)
            report_mismatch($sformatf("%s: data_two %0d, awaited %0d", where,
                                      got.data_two, want.data_two));
        if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("%s: byte_count %0d, awaited %0d", where,
                                      got.byte_count, want.byte_count));
        if (got.last_of_drain !== want.last_of_drain)
            report_mismatch($sformatf("%s: last_of_drain %b, awaited %b", where,
                                      got.last_of_drain, want.last_of_drain));
    endtask

    // Apply one accepted command to the FIFO model. Append whatever a service drains
    // to the awaited messages. Return how many it drained and the first of them.
    task automatic model_command(input cmd_item_t item, output int produced,
                                 output msg_item_t first);
        msg_word_t word;
        msg_item_t emitted;
        logic      is_enqueue;
        int        limit;
        produced   = 0;
        first      = '0;
        word       = '0;
        is_enqueue = 1'b1;
        case (item.command)
            CMD_NOTE_ON:  word = '{STATUS_NOTE_ON | {4'h0, item.channel},
                                   item.note_number, item.velocity};
            CMD_NOTE_OFF: word = '{STATUS_NOTE_OFF | {4'h0, item.channel},
                                   item.note_number, 7'd0};
            CMD_CLOCK:    word.status = STATUS_CLOCK;
            CMD_START:    word.status = STATUS_START;
            CMD_CONTINUE: word.status = STATUS_CONTINUE;
            CMD_STOP:     word.status = STATUS_STOP;
            default:      is_enqueue = 1'b0;
        endcase
        if (is_enqueue) begin
            // Drop silently once the ring is full
            if (fifo_words.size() >= FIFO_DEPTH)
                dropped_msgs++;
            else
                fifo_words.push_back(word);
        end else if (item.command == CMD_SERVICE) begin
            limit    = (budget_model > MAX_DRAIN) ? MAX_DRAIN : int'(budget_model);
            produced = (fifo_words.size() < limit) ? fifo_words.size() : limit;
            for (int k = 0; k < produced; k++) begin
                word                  = fifo_words.pop_front();
                emitted.status_byte   = word.status;
                emitted.data_one      = word.data_one;
                emitted.data_two      = word.data_two;
                emitted.byte_count    = (word.status >= STATUS_SYSTEM) ? BYTES_SHORT
                                                                       : BYTES_NOTE;
                emitted.last_of_drain = (k == produced - 1);
                if (k == 0)
                    first = emitted;
                pending_msgs.push_back(emitted);
            end
        end
    endtask

    // Present one command and hold it until its transfer. Idle beforehand at the rate
    // of the current phase. Keep valid high between back-to-back commands, so that
    // it is never lowered and raised in one step.
    task automatic send_command(input cmd_item_t item, output int produced,
                                output msg_item_t first);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        cmds_sent++;
        model_command(item, produced, first);
    endtask

    // Hold the sender off until every awaited message has come. Then give the back end
    // time to finish any command that yields nothing.
    task automatic wait_quiet();
        cmd_valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the budget only while the block is idle
    task automatic write_budget(input logic [BUDGET_WIDTH-1:0] value);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_write    <= 1'b0;
        budget_model  = value;
        budget_writes++;
    endtask

    // Receiver: stall at the phase rate and check every message transfer against the
    // oldest awaited message
    always @(posedge clk) begin : msg_side
        msg_item_t want;
        if (rst_n && msg_valid && msg_ready) begin
            if (pending_msgs.size() == 0) begin
                report_mismatch($sformatf("message %h %0d %0d with none awaited",
                                          msg.status_byte, msg.data_one, msg.data_two));
            end else begin
                want = pending_msgs.pop_front();
                check_msg($sformatf("message %0d", msgs_checked), msg, want);
                msgs_checked++;
            end
        end
        msg_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: end a run that hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d messages still awaited",
                     cycle_count, pending_msgs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Directed table. Reset leaves the budget at four. Cover the field extremes, every
    // command, the unused code, a full queue that drops, a zero budget, a budget above
    // sixteen, and a service on an empty queue.
    stim_row_t directed_rows [25] = '{
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_NOTE_ON,  4'd15, 7'd127, 7'd127}, 1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{8'h9F, 7'd127, 7'd127, BYTES_NOTE, 1'b1}},
        '{NO_WRITE, '{CMD_NOTE_OFF, 4'd0,  7'd0,   7'd127}, 1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{8'h80, 7'd0, 7'd0, BYTES_NOTE, 1'b1}},
        '{NO_WRITE, '{CMD_NOTE_ON,  4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{8'h90, 7'd0, 7'd0, BYTES_NOTE, 1'b1}},
        '{NO_WRITE, '{CMD_NOTE_OFF, 4'd15, 7'd127, 7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{8'h8F, 7'd127, 7'd0, BYTES_NOTE, 1'b1}},
        '{NO_WRITE, '{CMD_CLOCK,    4'd10, 7'd85,  7'd42},  1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{STATUS_CLOCK, 7'd0, 7'd0, BYTES_SHORT, 1'b1}},
        '{NO_WRITE, '{CMD_START,    4'd15, 7'd127, 7'd127}, 1, 0, '0},
        '{NO_WRITE, '{CMD_CONTINUE, 4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_STOP,     4'd5,  7'd42,  7'd85},  1, 0, '0},
        '{NO_WRITE, '{CMD_UNUSED,   4'd15, 7'd127, 7'd127}, 1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd15, 7'd127, 7'd127}, 1, 3,
          '{STATUS_START, 7'd0, 7'd0, BYTES_SHORT, 1'b0}},
        // Two more than the ring holds: the last two are dropped
        '{NO_WRITE, '{CMD_NOTE_ON,  4'd5,  7'd60,  7'd100}, FIFO_DEPTH + 2, NOT_TYPED, '0},
        '{0,        '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{31,       '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 16,
          '{8'h95, 7'd60, 7'd100, BYTES_NOTE, 1'b0}},
        '{1,        '{CMD_CLOCK,    4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_STOP,     4'd0,  7'd0,   7'd0},   1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{STATUS_CLOCK, 7'd0, 7'd0, BYTES_SHORT, 1'b1}},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{STATUS_STOP, 7'd0, 7'd0, BYTES_SHORT, 1'b1}},
        '{16,       '{CMD_NOTE_ON,  4'd10, 7'd1,   7'd64},  1, 0, '0},
        '{NO_WRITE, '{CMD_SERVICE,  4'd0,  7'd0,   7'd0},   1, 1,
          '{8'h9A, 7'd1, 7'd64, BYTES_NOTE, 1'b1}}
    };

    // Idling per random phase: none, sender, receiver, both
    int phase_gap   [4] = '{0, 74, 0, 26};
    int phase_stall [4] = '{0, 0, 74, 26};

    initial begin
        stim_row_t row;
        cmd_item_t item;
        msg_item_t first;
        int        produced;
        int        accepted;
        int        pick;
        logic [BUDGET_WIDTH-1:0] phase_budget;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table with no idling on either side. Check the rows with a typed-in
        // answer against the model first, so that a slip in the model shows up here.
        for (int i = 0; i < $size(directed_rows); i++) begin
            row = directed_rows[i];
            if (row.budget != NO_WRITE)
                write_budget(BUDGET_WIDTH'(row.budget));
            for (int r = 0; r < row.reps; r++) begin
                send_command(row.item, produced, first);
                if (row.exp_n != NOT_TYPED) begin
                    if (produced != row.exp_n)
                        report_mismatch($sformatf("row %0d: model drains %0d, table %0d",
                                                  i, produced, row.exp_n));
                    else if (produced > 0)
                        check_msg($sformatf("row %0d", i), first, row.want);
                end
            end
        end

        // Random phases. Favour enqueues so that a small budget lets the ring fill and
        // drop. Mix in services and the odd unused code. Every field runs its full range.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       phase_budget = BUDGET_WIDTH'($urandom_range(2, 15));
                1:       phase_budget = BUDGET_WIDTH'(MAX_DRAIN);
                2:       phase_budget = BUDGET_WIDTH'(1);
                default: phase_budget = BUDGET_WIDTH'($urandom_range(MAX_DRAIN + 1, 31));
            endcase
            // Between phases the sender pauses for every awaited message to come; the ring may
            // still hold messages after this pause
            write_budget(phase_budget);
            send_idle_pct = phase_gap[p];
            stall_pct     = phase_stall[p];
            accepted      = 0;
            while (accepted < ITEMS_PER_PHASE) begin
                pick             = $urandom_range(0, 99);
                item.channel     = 4'($urandom_range(0, 15));
                item.note_number = 7'($urandom_range(0, 127));
                item.velocity    = 7'($urandom_range(0, 127));
                if (pick < 4)
                    item.command = CMD_UNUSED;
                else if (pick < 26)
                    item.command = CMD_SERVICE;
                else
                    item.command = 3'($urandom_range(CMD_NOTE_ON, CMD_STOP));
                send_command(item, produced, first);
                if (item.command != CMD_UNUSED)
                    accepted++;
            end
        end

        // Flush whatever is still queued, then wait out the tail
        write_budget(BUDGET_WIDTH'(MAX_DRAIN));
        send_idle_pct = 0;
        stall_pct     = 0;
        item          = '{CMD_SERVICE, 4'd0, 7'd0, 7'd0};
        send_command(item, produced, first);
        wait_quiet();

        $display("ran %0d command transfers and checked %0d message transfers",
                 cmds_sent, msgs_checked);
        $display("%0d enqueues dropped on a full ring, %0d budget writes, 4 idling phases",
                 dropped_msgs, budget_writes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
